// ----- design/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// Request and response payloads, opcodes, status codes, back-end states.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int TYPES_DEF   = 4;
  localparam int SLOTS_DEF   = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam int TYPE_FIELD_W = 8;
  localparam int INDEX_W      = 32;
  localparam int SALT_W       = 24;
  localparam int OBJ_W        = 48;
  localparam int DEL_W        = 4;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_SALT     = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [TYPE_FIELD_W-1:0] table_type;
    logic [OBJ_W-1:0]        object_ref;
    logic [INDEX_W-1:0]      handle_index;
    logic [SALT_W-1:0]       handle_salt;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        result_index;
    logic [SALT_W-1:0] result_salt;
    logic [OBJ_W-1:0]  result_object;
    logic              delete_request;
  } rsp_t;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]              opcode;
    logic                    bad_type;
    logic [TYPE_FIELD_W-1:0] type_sel;
    logic [OBJ_W-1:0]        object_ref;
    logic [INDEX_W-1:0]      handle_index;
    logic [SALT_W-1:0]       handle_salt;
  } cls_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SLOT,
    B_EXEC
  } back_state_t;

endpackage

// ----- design/ght_front.sv -----
// ----------------------------------------------------------------------------
// ght_front: request intake and classification
// Registers each request, flags a bad type and clamps the type select.
// ----------------------------------------------------------------------------
module ght_front import ght_pkg::*; #(
  parameter int TYPES = TYPES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic q_valid,
  input  logic q_ready,
  output cls_t q_item
);

  logic valid_r;
  cls_t item_r;
  cls_t item_next;
  logic bad;
  logic take;

  always_comb begin
    bad = (req.table_type == '0) || (32'(req.table_type) >= TYPES);
    item_next.opcode       = req.opcode;
    item_next.bad_type     = bad;
    // clamp so the back end never indexes past its per-type state
    item_next.type_sel     = bad ? '0 : req.table_type;
    item_next.object_ref   = req.object_ref;
    item_next.handle_index = req.handle_index;
    item_next.handle_salt  = req.handle_salt;
  end

  assign req_stall = valid_r && !q_ready;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (q_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_next;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

// ----- design/ght_queue.sv -----
// ----------------------------------------------------------------------------
// ght_queue: short FIFO between front end and back end
// Lets the intake keep taking items while the back end works.
// ----------------------------------------------------------------------------
module ght_queue import ght_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cls_t push_item,
  output logic pop_valid,
  input  logic pop,
  output cls_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/ght_back.sv -----
// ----------------------------------------------------------------------------
// ght_back: handle table execution
// Reads the free stack, then the slot, then checks and writes back.
// ----------------------------------------------------------------------------
module ght_back import ght_pkg::*; #(
  parameter int TYPES = TYPES_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DEL_W-1:0] cfg_wdata,
  input  logic             q_valid,
  input  cls_t             q_item,
  output logic             q_pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  localparam int TYPE_W    = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ADDR_W    = TYPE_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  logic [SALT_W-1:0] salt_mem  [MEM_DEPTH];
  logic [OBJ_W-1:0]  obj_mem   [MEM_DEPTH];
  logic [SLOT_W-1:0] stack_mem [MEM_DEPTH];

  logic [CNT_W-1:0] used  [TYPES];
  logic [CNT_W-1:0] depth [TYPES];
  logic [DEL_W-1:0] del_en;

  back_state_t state;
  back_state_t state_next;
  cls_t        cur;
  logic [SLOT_W-1:0] slot_sel;
  logic [SLOT_W-1:0] stack_q;
  logic [SALT_W-1:0] salt_q;
  logic [OBJ_W-1:0]  obj_q;
  logic              rsp_valid_r;
  rsp_t              rsp_r;

  logic [TYPE_W-1:0] q_ti;
  logic [TYPE_W-1:0] cur_ti;
  logic [CNT_W-1:0]  q_dm1;
  logic [CNT_W-1:0]  used_cur;
  logic [CNT_W-1:0]  depth_cur;
  logic              pop_ok;
  logic [SLOT_W-1:0] slot_c;
  logic [ADDR_W-1:0] stack_rd_addr;
  logic [ADDR_W-1:0] slot_addr;
  logic [ADDR_W-1:0] exec_addr;
  logic [ADDR_W-1:0] push_addr;
  logic [SLOT_W+7:0] slot_wide;
  logic [15:0]       del_wide;

  logic  slot_rd;
  logic  exec_fire;
  logic  alloc_new;
  logic  alloc_pop;
  logic  do_free;
  logic  push;
  rsp_t  res;

  assign q_ti      = q_item.type_sel[TYPE_W-1:0];
  assign cur_ti    = cur.type_sel[TYPE_W-1:0];
  assign q_dm1     = depth[q_ti] - 1'b1;
  assign used_cur  = used[cur_ti];
  assign depth_cur = depth[cur_ti];
  assign pop_ok    = (depth_cur != '0);

  assign stack_rd_addr = {q_ti, q_dm1[SLOT_W-1:0]};

  always_comb begin
    if (cur.opcode == OP_ALLOC) begin
      slot_c = pop_ok ? stack_q : used_cur[SLOT_W-1:0];
    end else begin
      slot_c = cur.handle_index[SLOT_W-1:0];
    end
  end

  assign slot_addr = {cur_ti, slot_c};
  assign exec_addr = {cur_ti, slot_sel};
  assign push_addr = {cur_ti, depth_cur[SLOT_W-1:0]};
  assign slot_wide = {8'b0, slot_sel};
  assign del_wide  = 16'(del_en);

  // check and form the result of the current item
  always_comb begin
    res       = '0;
    alloc_new = 1'b0;
    alloc_pop = 1'b0;
    do_free   = 1'b0;
    push      = 1'b0;
    case (cur.opcode)
      OP_ALLOC: begin
        if (cur.bad_type) begin
          res.status = ST_BAD_TYPE;
        end else if (pop_ok) begin
          alloc_pop          = 1'b1;
          res.result_index   = slot_wide[7:0];
          res.result_salt    = salt_q;
        end else if (used_cur >= CNT_W'(SLOTS)) begin
          res.status = ST_FULL;
        end else begin
          alloc_new          = 1'b1;
          res.result_index   = slot_wide[7:0];
        end
      end
      OP_GET, OP_FREE: begin
        if (cur.bad_type) begin
          res.status = ST_BAD_TYPE;
        end else if (cur.handle_index >= 32'(used_cur)) begin
          res.status = ST_RANGE;
        end else if (salt_q != cur.handle_salt) begin
          res.status = ST_SALT;
        end else begin
          res.result_object = obj_q;
          if (cur.opcode == OP_FREE) begin
            do_free            = 1'b1;
            res.delete_request = del_wide[cur.type_sel[3:0]];
            // a stack already holding every slot drops the push
            push               = (depth_cur < CNT_W'(SLOTS));
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = B_SLOT;
        end
      end
      B_SLOT: begin
        state_next = B_EXEC;
      end
      B_EXEC: begin
        if (!rsp_valid_r || !rsp_stall) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    slot_rd   = 1'b0;
    exec_fire = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop = q_valid;
      end
      B_SLOT: begin
        slot_rd = 1'b1;
      end
      B_EXEC: begin
        exec_fire = !rsp_valid_r || !rsp_stall;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      del_en <= '0;
    end else if (cfg_we) begin
      del_en <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TYPES; i++) begin
        used[i]  <= '0;
        depth[i] <= '0;
      end
    end else if (exec_fire) begin
      if (alloc_new) begin
        used[cur_ti] <= used_cur + 1'b1;
      end
      if (alloc_pop) begin
        depth[cur_ti] <= depth_cur - 1'b1;
      end else if (push) begin
        depth[cur_ti] <= depth_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (slot_rd) begin
      slot_sel <= slot_c;
    end
  end

  // free stack: read on pop from the queue, push on a valid free
  always_ff @(posedge clk) begin
    if (q_pop) begin
      stack_q <= stack_mem[stack_rd_addr];
    end
    if (exec_fire && push) begin
      stack_mem[push_addr] <= slot_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_rd) begin
      salt_q <= salt_mem[slot_addr];
    end
    if (exec_fire && alloc_new) begin
      salt_mem[exec_addr] <= '0;
    end else if (exec_fire && do_free) begin
      salt_mem[exec_addr] <= salt_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_rd) begin
      obj_q <= obj_mem[slot_addr];
    end
    if (exec_fire && (alloc_new || alloc_pop)) begin
      obj_mem[exec_addr] <= cur.object_ref;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_r <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid_r <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp_r <= res;
    end
  end

  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

`ifndef NO_ASSERTIONS
  a_pop_starts_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == B_SLOT)
    else $error("popped item did not move to slot read");

  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> rsp_valid && state == B_IDLE)
    else $error("executed item produced no response");

  a_new_slot_counts: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && alloc_new) |=> used_cur == CNT_W'($past(used_cur) + 1'b1))
    else $error("fresh allocate did not advance slots used");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && push) |=> depth_cur == CNT_W'($past(depth_cur) + 1'b1))
    else $error("free did not advance stack depth");
`endif

endmodule

// ----- design/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table: typed handle table with generation salts
// Allocate, get and free of handles over one slot bank per type.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on req_valid / req_stall / req and are taken at an edge
//   with req_valid high and req_stall low. Each request gives exactly one
//   response on rsp_valid / rsp_stall / rsp, in request order.
//   cfg_we writes cfg_wdata into the per-type deleter enable; write it only
//   while no request is in flight.
//   The back end takes one item at a time and pops the next only after the
//   current one is written back: it reads the free stack on pop, then the
//   slot salt/object, then checks and writes back to its single-port slot
//   memories.
//   A two-entry queue and an intake register absorb requests while the back
//   end works; the back end holds a finished response in its output register
//   while rsp_stall is high, and holds the next item back from execution.
//   Reset clears the slots-used and free-depth counters of every type and
//   the deleter enable; slot and stack memories are not cleared, since only
//   written entries are ever used.
// ----------------------------------------------------------------------------
module generational_handle_table import ght_pkg::*; #(
  parameter int TYPES = TYPES_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DEL_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  logic f_valid;
  logic f_ready;
  cls_t f_item;
  logic b_valid;
  logic b_pop;
  cls_t b_item;

  ght_front #(
    .TYPES(TYPES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  ght_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_item (f_item),
    .pop_valid (b_valid),
    .pop       (b_pop),
    .pop_item  (b_item)
  );

  ght_back #(
    .TYPES(TYPES),
    .SLOTS(SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (b_valid),
    .q_item   (b_item),
    .q_pop    (b_pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

// ----- tb/handle_table_checker.sv -----
// ----------------------------------------------------------------------------
// handle_table_checker: reply predictor and comparator for the handle table
// Watches the request, reply and register ports. Keeps its own copy of the
// slot banks, free stacks and deleter enable, queues the reply each accepted
// request should give, and compares every accepted reply field by field.
// ----------------------------------------------------------------------------
module handle_table_checker import ght_pkg::*; #(
  parameter int TYPES = TYPES_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DEL_W-1:0] cfg_wdata,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  output int               mismatches,
  output int               replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SALT_W-1:0]  salt_mem    [TYPES][SLOTS];
  logic [OBJ_W-1:0]   obj_mem     [TYPES][SLOTS];
  logic [INDEX_W-1:0] freed_slots [TYPES][SLOTS];
  int unsigned        used_cnt    [TYPES];
  int unsigned        stack_top   [TYPES];
  logic [DEL_W-1:0]   del_en;
  rsp_t               replies_due [$];

  initial begin
    mismatches   = 0;
    replies_owed = 0;
  end

  // Reply of the table to one request; updates the copy of the table state.
  function automatic rsp_t table_reply(input req_t r);
    rsp_t        o;
    int unsigned t;
    int unsigned d;
    int unsigned slot;
    o = '0;
    t = 32'(r.table_type);
    case (r.opcode)
      OP_ALLOC: begin
        if (t == 0 || t >= TYPES) begin
          o.status = ST_BAD_TYPE;
        end else if (stack_top[t] > 0) begin
          // pop the most recently freed slot, keep its salt
          d = stack_top[t] - 1;
          slot = freed_slots[t][d] % SLOTS;
          stack_top[t] = d;
          obj_mem[t][slot] = r.object_ref;
          o.result_index = slot[7:0];
          o.result_salt = salt_mem[t][slot];
        end else if (used_cnt[t] >= SLOTS) begin
          o.status = ST_FULL;
        end else begin
          slot = used_cnt[t];
          used_cnt[t] = slot + 1;
          salt_mem[t][slot] = '0;
          obj_mem[t][slot] = r.object_ref;
          o.result_index = slot[7:0];
        end
      end
      OP_GET, OP_FREE: begin
        if (t == 0 || t >= TYPES) begin
          o.status = ST_BAD_TYPE;
        end else if (r.handle_index >= used_cnt[t]) begin
          o.status = ST_RANGE;
        end else if (salt_mem[t][r.handle_index] != r.handle_salt) begin
          o.status = ST_SALT;
        end else begin
          slot = r.handle_index;
          o.result_object = obj_mem[t][slot];
          if (r.opcode == OP_FREE) begin
            o.delete_request = (t < DEL_W) ? del_en[t] : 1'b0;
            // a full stack drops the push, the salt still advances
            if (stack_top[t] < SLOTS) begin
              freed_slots[t][stack_top[t]] = r.handle_index;
              stack_top[t] = stack_top[t] + 1;
            end
            salt_mem[t][slot] = salt_mem[t][slot] + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (used_cnt[i]) begin
        used_cnt[i]  = 0;
        stack_top[i] = 0;
      end
      del_en = '0;
      replies_due.delete();
    end else begin
      // compare first, so a reply never meets its own request's prediction
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: reply %0h arrived with none outstanding", $realtime, rsp);
          end
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("result_index", want.result_index, rsp.result_index);
          check_field("result_salt", want.result_salt, rsp.result_salt);
          check_field("result_object", want.result_object, rsp.result_object);
          check_field("delete_request", want.delete_request, rsp.delete_request);
        end
      end
      if (cfg_we) del_en = cfg_wdata;
      if (req_valid && !req_stall) begin
        replies_due.insert(replies_due.size(), table_reply(req));
      end
    end
    replies_owed = replies_due.size();
  end

endmodule

// ----- tb/tb_generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// tb_generational_handle_table: stimulus and verdict for the handle table
// Drives directed handle cases, then random mixes, a fill of one type to a
// full table and an overflow of its free stack, under random idling on both
// channels and several deleter settings. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_generational_handle_table;
  import ght_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TYPES          = TYPES_DEF;
  localparam int SLOTS          = SLOTS_DEF;
  localparam int FILL_TYPE      = TYPES - 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [DEL_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;

  int mismatches;
  int replies_owed;
  int idle_pct = 32;
  int quiet_cycles = 0;

  // Stimulus-side view of each type: slots taken, stack depth, current salts.
  int unsigned       taken    [TYPES];
  int unsigned       freed    [TYPES];
  logic [SALT_W-1:0] cur_salt [TYPES][SLOTS];

  always #6 clk = ~clk;

  generational_handle_table #(.TYPES(TYPES), .SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  handle_table_checker #(.TYPES(TYPES), .SLOTS(SLOTS)) u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .replies_owed (replies_owed)
  );

  always @(posedge clk) rsp_stall <= ($urandom_range(99) < idle_pct);

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** generational_handle_table: FAILED **");
      $finish;
    end
  end

  function automatic logic [OBJ_W-1:0] rand_obj();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[OBJ_W-1:0];
  endfunction

  // Follow what an issued item does to slots taken, stack depth and salts.
  function automatic void track(input req_t r);
    int unsigned t;
    t = 32'(r.table_type);
    if (t == 0 || t >= TYPES) return;
    if (r.opcode == OP_ALLOC) begin
      if (freed[t] > 0) begin
        freed[t]--;
      end else if (taken[t] < SLOTS) begin
        cur_salt[t][taken[t]] = '0;
        taken[t]++;
      end
    end else if (r.opcode == OP_FREE && r.handle_index < taken[t]) begin
      if (r.handle_salt == cur_salt[t][r.handle_index]) begin
        if (freed[t] < SLOTS) freed[t]++;
        cur_salt[t][r.handle_index] = cur_salt[t][r.handle_index] + 1'b1;
      end
    end
  endfunction

  // Get or free of a live slot with its current salt.
  function automatic req_t handle_req(input logic [1:0] op, input int unsigned t);
    req_t        r;
    int unsigned idx;
    idx = (taken[t] > 0) ? $urandom_range(taken[t] - 1) : 0;
    r.opcode       = op;
    r.table_type   = 8'(t);
    r.object_ref   = rand_obj();
    r.handle_index = idx;
    r.handle_salt  = cur_salt[t][idx];
    return r;
  endfunction

  function automatic req_t random_item();
    req_t        r;
    int unsigned pick;
    int unsigned t;
    pick = $urandom_range(99);
    t = $urandom_range(TYPES - 1, 1);
    r.opcode       = OP_ALLOC;
    r.table_type   = 8'(t);
    r.object_ref   = rand_obj();
    r.handle_index = $urandom();
    r.handle_salt  = 24'($urandom());
    if (pick < 35) begin
      return r;
    end else if (pick < 85 && taken[t] > 0) begin
      r = handle_req((pick < 60) ? OP_GET : OP_FREE, t);
      // now and then a stale handle
      if ($urandom_range(9) == 0) r.handle_salt = r.handle_salt - 1'b1;
    end else if (pick < 89) begin
      r.opcode = 2'($urandom_range(3));
      r.table_type = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, TYPES));
    end else if (pick < 95) begin
      r.opcode = ($urandom_range(1) == 0) ? OP_GET : OP_FREE;
      if ($urandom_range(1) == 0 || r.handle_index < taken[t]) r.handle_index = taken[t];
    end else if (pick < 98) begin
      r.opcode = OP_UNDEF;
    end else begin
      r.opcode = OP_GET;
    end
    return r;
  endfunction

  task automatic send_item(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    track(r);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [7:0] t,
                             input logic [OBJ_W-1:0] obj, input logic [INDEX_W-1:0] idx,
                             input logic [SALT_W-1:0] salt);
    req_t r;
    r = '{op, t, obj, idx, salt};
    send_item(r);
  endtask

  // Hold the sender until every reply is back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  task automatic set_deleter(input logic [DEL_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    foreach (taken[i]) begin
      taken[i] = 0;
      freed[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_deleter(4'b1010);
    // bad types on every opcode, and the undefined opcode
    send_fields(OP_ALLOC, 8'd0, '1, '1, '1);
    send_fields(OP_ALLOC, 8'd255, rand_obj(), '0, '0);
    send_fields(OP_GET, 8'(TYPES), '0, '0, '0);
    send_fields(OP_FREE, 8'd0, '0, '0, '0);
    send_fields(OP_UNDEF, '1, '1, '1, '1);
    send_fields(OP_GET, 8'd1, '0, '0, '0);
    send_fields(OP_ALLOC, 8'd1, '1, '1, '1);
    send_fields(OP_ALLOC, 8'd1, '0, '0, '0);
    send_fields(OP_ALLOC, 8'd2, rand_obj(), '0, '0);
    send_fields(OP_GET, 8'd1, '0, 32'd0, 24'd0);
    send_fields(OP_GET, 8'd1, '0, '1, 24'd0);
    send_fields(OP_GET, 8'd1, '0, 32'd2, 24'd0);
    send_fields(OP_GET, 8'd1, '0, 32'd1, '1);
    send_fields(OP_FREE, 8'd1, '0, 32'd0, 24'd0);
    // get and repeated free of the freed slot with its advanced salt
    send_fields(OP_GET, 8'd1, '0, 32'd0, 24'd1);
    send_fields(OP_FREE, 8'd1, '0, 32'd0, 24'd1);
    // two pops of the same slot, then a fresh slot
    send_fields(OP_ALLOC, 8'd1, rand_obj(), '0, '0);
    send_fields(OP_ALLOC, 8'd1, rand_obj(), '0, '0);
    send_fields(OP_ALLOC, 8'd1, rand_obj(), '0, '0);
    send_fields(OP_FREE, 8'd2, '0, 32'd0, 24'd0);
    send_fields(OP_FREE, 8'd1, '0, 32'd1, 24'd1);
    send_fields(OP_FREE, 8'(FILL_TYPE), '0, 32'd0, 24'd0);
    send_fields(OP_GET, 8'd2, '0, 32'd0, 24'd1);

    set_deleter(4'hF);
    repeat (150) send_item(random_item());

    set_deleter(4'h0);
    // no idling while one type is filled up to a full table
    idle_pct = 0;
    while (!(taken[FILL_TYPE] >= SLOTS && freed[FILL_TYPE] == 0)) begin
      if ($urandom_range(9) == 0 && taken[FILL_TYPE] > 0) begin
        send_item(handle_req(OP_GET, FILL_TYPE));
      end else begin
        send_fields(OP_ALLOC, 8'(FILL_TYPE), rand_obj(), $urandom(), 24'($urandom()));
      end
    end
    repeat (3) send_fields(OP_ALLOC, 8'(FILL_TYPE), rand_obj(), $urandom(), 24'($urandom()));
    idle_pct = 32;

    set_deleter(4'($urandom_range(15)));
    // push the free stack past its depth
    repeat (270) begin
      if ($urandom_range(9) == 0) begin
        send_item(random_item());
      end else begin
        send_item(handle_req(OP_FREE, FILL_TYPE));
      end
    end
    repeat (6) send_fields(OP_ALLOC, 8'(FILL_TYPE), rand_obj(), $urandom(), 24'($urandom()));

    set_deleter(4'b0101);
    repeat (60) send_item(random_item());

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("** generational_handle_table: PASSED **");
    end else begin
      $display("** generational_handle_table: FAILED **");
    end
    $finish;
  end

endmodule
